// ===== design/vrt_pkg.sv =====
// Shared types and constants for the voxel ray traversal block.
// Used by vrt_ctrl, vrt_dpath and voxel_ray_traversal_3d; depends on nothing.
package vrt_pkg;

  localparam int COORD_W    = 24;
  localparam int FRAC_BITS  = 8;
  localparam int INDEX_BITS = COORD_W - FRAC_BITS;
  localparam int MAX_VOXELS = 63;
  localparam int MAX_STEPS  = 4096;

  localparam int DELTA_W  = INDEX_BITS + 1;
  localparam int NUM_W    = FRAC_BITS + 1;
  localparam int XNUM_W   = FRAC_BITS + $clog2(MAX_STEPS + 2);
  localparam int XP_W     = XNUM_W + DELTA_W;
  localparam int LEN_W    = COORD_W;
  localparam int Q_W      = INDEX_BITS + FRAC_BITS + 2;
  localparam int DIST_W   = 2 * Q_W;
  localparam int VOX_W    = $clog2(MAX_VOXELS + 1);
  localparam int STEP_W   = $clog2(MAX_STEPS + 1);

  localparam int CFG_W     = INDEX_BITS;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_Z = 3'd5;

  localparam int SETUP_IDX_W = 2;
  localparam logic [SETUP_IDX_W-1:0] SETUP_FIRST = 2'd0;
  localparam logic [SETUP_IDX_W-1:0] SETUP_LAST  = 2'd2;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] start_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_y;
    logic signed [COORD_W-1:0] end_z;
  } ray_t;

  typedef struct packed {
    logic signed [INDEX_BITS-1:0] voxel_x;
    logic signed [INDEX_BITS-1:0] voxel_y;
    logic signed [INDEX_BITS-1:0] voxel_z;
    logic                         voxel_valid;
    logic                         last;
    logic                         overflow;
  } result_t;

  typedef struct packed {
    logic                   load;
    logic                   setup;
    logic [SETUP_IDX_W-1:0] setup_idx;
    logic                   walk;
    logic                   mark;
  } cmd_t;

  typedef struct packed {
    logic any_move;
    logic stop;
  } stat_t;

endpackage

// ===== design/vrt_ctrl.sv =====
// Sequencer for the voxel ray traversal: idle, setup, walk, marker.
// Depends on vrt_pkg; drives vrt_dpath through cmd_t and reads stat_t.
module vrt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  vrt_pkg::stat_t stat,
  output vrt_pkg::cmd_t  cmd
);
  import vrt_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_WALK  = 2'd2;
  localparam logic [1:0] S_MARK  = 2'd3;

  logic [1:0]             state_r, state_nxt;
  logic [SETUP_IDX_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cmd           = '0;
    cmd.setup_idx = idx_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = start;
        idx_nxt  = SETUP_FIRST;
        if (start) begin
          state_nxt = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup = 1'b1;
        idx_nxt   = idx_r + 1'b1;
        if (idx_r == SETUP_LAST) begin
          state_nxt = stat.any_move ? S_WALK : S_MARK;
        end
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (stat.stop) begin
          state_nxt = S_MARK;
        end
      end
      S_MARK: begin
        cmd.mark  = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= SETUP_FIRST;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ===== design/vrt_dpath.sv =====
// Datapath of the voxel ray traversal: bounds registers, ray setup, DDA stepper,
// incremental cross products and squared distance, result register. Depends on vrt_pkg.
module vrt_dpath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  vrt_pkg::cmd_t                  cmd,
  input  vrt_pkg::ray_t                  in_data,
  input  logic                           cfg_we,
  input  logic [vrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vrt_pkg::CFG_W-1:0]      cfg_data,
  output vrt_pkg::stat_t                 stat,
  output logic                           out_valid,
  output vrt_pkg::result_t               out_data
);
  import vrt_pkg::*;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  localparam int P01 = 0;
  localparam int P10 = 1;
  localparam int P02 = 2;
  localparam int P20 = 3;
  localparam int P12 = 4;
  localparam int P21 = 5;

  localparam logic [NUM_W-1:0]  ONE_VOXEL = NUM_W'(1) << FRAC_BITS;
  localparam logic [DIST_W-1:0] SQ_ONE    = DIST_W'(1) << (2 * FRAC_BITS);

  // bounds registers
  logic signed [INDEX_BITS-1:0] min_r [3];
  logic signed [INDEX_BITS-1:0] max_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        min_r[a] <= {1'b1, {(INDEX_BITS-1){1'b0}}};
        max_r[a] <= {1'b0, {(INDEX_BITS-1){1'b1}}};
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MIN_X: min_r[0] <= cfg_data;
        REG_MIN_Y: min_r[1] <= cfg_data;
        REG_MIN_Z: min_r[2] <= cfg_data;
        REG_MAX_X: max_r[0] <= cfg_data;
        REG_MAX_Y: max_r[1] <= cfg_data;
        REG_MAX_Z: max_r[2] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // per-ray state
  logic signed [INDEX_BITS-1:0] cur_r   [3];
  logic signed [INDEX_BITS-1:0] end_r   [3];
  logic                         neg_r   [3];
  logic [DELTA_W-1:0]           absd_r  [3];
  logic [NUM_W-1:0]             num_r   [3];
  logic [FRAC_BITS-1:0]         frac_r  [3];
  logic [LEN_W-1:0]             len_r   [3];
  logic signed [Q_W-1:0]        q_r     [3];
  logic [XP_W-1:0]              xp_r    [6];
  logic [DIST_W-1:0]            dist_r;
  logic [DIST_W-1:0]            lensq_r;
  logic [VOX_W-1:0]             vox_r;
  logic [STEP_W-1:0]            steps_r;
  logic                         ovf_r;
  logic                         out_valid_r;
  result_t                      out_data_r;

  // load: voxel indices, deltas, first crossing numerators, axis lengths
  logic signed [COORD_W-1:0]    s_in    [3];
  logic signed [COORD_W-1:0]    e_in    [3];
  logic signed [INDEX_BITS-1:0] cur_in  [3];
  logic signed [INDEX_BITS-1:0] end_in  [3];
  logic signed [DELTA_W-1:0]    d_in    [3];
  logic [DELTA_W-1:0]           absd_in [3];
  logic [COORD_W-1:0]           sneg_in [3];
  logic [FRAC_BITS-1:0]         fd_in   [3];
  logic [NUM_W-1:0]             num_in  [3];
  logic signed [COORD_W:0]      l_in    [3];
  logic [COORD_W:0]             labs_in [3];

  always_comb begin
    s_in[0] = in_data.start_x;
    s_in[1] = in_data.start_y;
    s_in[2] = in_data.start_z;
    e_in[0] = in_data.end_x;
    e_in[1] = in_data.end_y;
    e_in[2] = in_data.end_z;
    for (int a = 0; a < 3; a++) begin
      cur_in[a]  = s_in[a][COORD_W-1:FRAC_BITS];
      end_in[a]  = e_in[a][COORD_W-1:FRAC_BITS];
      d_in[a]    = {end_in[a][INDEX_BITS-1], end_in[a]} - {cur_in[a][INDEX_BITS-1], cur_in[a]};
      absd_in[a] = d_in[a][DELTA_W-1] ? DELTA_W'(-d_in[a]) : DELTA_W'(d_in[a]);
      sneg_in[a] = -s_in[a];
      fd_in[a]   = d_in[a][DELTA_W-1] ? sneg_in[a][FRAC_BITS-1:0] : s_in[a][FRAC_BITS-1:0];
      num_in[a]  = ONE_VOXEL - {1'b0, fd_in[a]};
      l_in[a]    = {e_in[a][COORD_W-1], e_in[a]} - {s_in[a][COORD_W-1], s_in[a]};
      labs_in[a] = l_in[a][COORD_W] ? (COORD_W+1)'(-l_in[a]) : (COORD_W+1)'(l_in[a]);
    end
  end

  // setup: squared ray length accumulated over the setup steps, cross products, start distance
  logic [LEN_W-1:0]       len_sel;
  logic [2*LEN_W-1:0]     len_sq;
  logic [DIST_W-1:0]      lensq_nxt;
  logic [2*FRAC_BITS-1:0] fsq [3];
  logic [DIST_W-1:0]      dist_init;
  logic [XP_W-1:0]        xp_init [6];

  always_comb begin
    len_sel   = len_r[cmd.setup_idx];
    len_sq    = len_sel * len_sel;
    lensq_nxt = ((cmd.setup_idx == SETUP_FIRST) ? '0 : lensq_r) + DIST_W'(len_sq);
    for (int a = 0; a < 3; a++) begin
      fsq[a] = frac_r[a] * frac_r[a];
    end
    dist_init    = DIST_W'(fsq[0]) + DIST_W'(fsq[1]) + DIST_W'(fsq[2]);
    xp_init[P01] = XP_W'(num_r[0]) * XP_W'(absd_r[1]);
    xp_init[P10] = XP_W'(num_r[1]) * XP_W'(absd_r[0]);
    xp_init[P02] = XP_W'(num_r[0]) * XP_W'(absd_r[2]);
    xp_init[P20] = XP_W'(num_r[2]) * XP_W'(absd_r[0]);
    xp_init[P12] = XP_W'(num_r[1]) * XP_W'(absd_r[2]);
    xp_init[P21] = XP_W'(num_r[2]) * XP_W'(absd_r[1]);
  end

  // walk: one voxel per cycle
  logic                  nz [3];
  logic                  inb, cap, far, at_end, step_lim;
  logic                  emit, stop, stop_ovf, step;
  logic                  e01, e02, e12;
  logic [1:0]            ax;
  logic signed [Q_W-1:0] q_sel;
  logic                  neg_sel;
  logic [DIST_W-1:0]     dq;
  logic [DIST_W-1:0]     dist_step;
  logic [XP_W-1:0]       xinc [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      nz[a]   = (absd_r[a] != '0);
      xinc[a] = XP_W'(absd_r[a]) << FRAC_BITS;
    end
    inb = 1'b1;
    for (int a = 0; a < 3; a++) begin
      inb = inb & (cur_r[a] >= min_r[a]) & (cur_r[a] < max_r[a]);
    end
    cap      = (vox_r >= VOX_W'(MAX_VOXELS));
    far      = (dist_r > lensq_r);
    at_end   = (cur_r[0] == end_r[0]) & (cur_r[1] == end_r[1]) & (cur_r[2] == end_r[2]);
    step_lim = (steps_r >= STEP_W'(MAX_STEPS));
    emit     = inb & ~cap;
    stop     = 1'b1;
    stop_ovf = 1'b0;
    priority if (inb & cap) begin
      stop_ovf = 1'b1;
    end else if (inb & far) begin
      stop_ovf = 1'b0;
    end else if (at_end) begin
      stop_ovf = 1'b0;
    end else if (step_lim) begin
      stop_ovf = 1'b1;
    end else begin
      stop = 1'b0;
    end
    step = cmd.walk & ~stop;

    e01 = nz[0] & (~nz[1] | (xp_r[P01] < xp_r[P10]));
    e02 = nz[0] & (~nz[2] | (xp_r[P02] < xp_r[P20]));
    e12 = nz[1] & (~nz[2] | (xp_r[P12] < xp_r[P21]));
    if (e01) begin
      ax = e02 ? AX_X : AX_Z;
    end else begin
      ax = e12 ? AX_Y : AX_Z;
    end

    q_sel     = q_r[ax];
    neg_sel   = neg_r[ax];
    dq        = {{(DIST_W-Q_W-FRAC_BITS-1){q_sel[Q_W-1]}}, q_sel, {(FRAC_BITS+1){1'b0}}};
    dist_step = dist_r + (neg_sel ? -dq : dq) + SQ_ONE;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int a = 0; a < 3; a++) begin
        cur_r[a]  <= cur_in[a];
        end_r[a]  <= end_in[a];
        neg_r[a]  <= d_in[a][DELTA_W-1];
        absd_r[a] <= absd_in[a];
        num_r[a]  <= num_in[a];
        frac_r[a] <= s_in[a][FRAC_BITS-1:0];
        len_r[a]  <= labs_in[a][LEN_W-1:0];
      end
    end
    if (cmd.setup) begin
      lensq_r <= lensq_nxt;
      if (cmd.setup_idx == SETUP_FIRST) begin
        for (int a = 0; a < 3; a++) begin
          q_r[a] <= -Q_W'(frac_r[a]);
        end
        for (int p = 0; p < 6; p++) begin
          xp_r[p] <= xp_init[p];
        end
        dist_r  <= dist_init;
        vox_r   <= '0;
        steps_r <= '0;
        ovf_r   <= 1'b0;
      end
    end
    if (cmd.walk) begin
      if (emit) begin
        vox_r <= vox_r + 1'b1;
      end
      if (stop) begin
        ovf_r <= stop_ovf;
      end
    end
    if (step) begin
      for (int a = 0; a < 3; a++) begin
        if (ax == 2'(a)) begin
          cur_r[a] <= neg_r[a] ? cur_r[a] - 1'b1 : cur_r[a] + 1'b1;
          q_r[a]   <= neg_r[a] ? q_r[a] - Q_W'(ONE_VOXEL) : q_r[a] + Q_W'(ONE_VOXEL);
        end
      end
      unique case (ax)
        AX_X: begin
          xp_r[P01] <= xp_r[P01] + xinc[1];
          xp_r[P02] <= xp_r[P02] + xinc[2];
        end
        AX_Y: begin
          xp_r[P10] <= xp_r[P10] + xinc[0];
          xp_r[P12] <= xp_r[P12] + xinc[2];
        end
        AX_Z: begin
          xp_r[P20] <= xp_r[P20] + xinc[0];
          xp_r[P21] <= xp_r[P21] + xinc[1];
        end
        default: begin
        end
      endcase
      dist_r  <= dist_step;
      steps_r <= steps_r + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.walk & emit) | cmd.mark;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mark) begin
      out_data_r <= '{voxel_x: '0, voxel_y: '0, voxel_z: '0,
                      voxel_valid: 1'b0, last: 1'b1, overflow: ovf_r};
    end else begin
      out_data_r <= '{voxel_x: cur_r[0], voxel_y: cur_r[1], voxel_z: cur_r[2],
                      voxel_valid: 1'b1, last: 1'b0, overflow: 1'b0};
    end
  end

  assign stat.any_move = nz[0] | nz[1] | nz[2];
  assign stat.stop     = stop;
  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;

endmodule

// ===== design/voxel_ray_traversal_3d.sv =====
// Top level of the voxel ray traversal block: sequencer plus datapath.
// Depends on vrt_pkg, vrt_ctrl and vrt_dpath.
//
// A ray is taken when start is high and busy is low. Setup comes first, then the
// stepper visits one voxel per cycle and one marker cycle follows once the walk
// stops. A ray whose start and end fall in one voxel skips the walk. Each voxel
// result comes out the cycle after the walk cycle that visits it, and the
// end-of-ray marker comes out in the first cycle after busy falls. At most one
// result appears per cycle, held on out_data for that one cycle while out_valid
// is high; the receiver cannot stall it and must take every result as it comes.
// The user must write the bounds registers through the cfg port only while busy
// is low; the block itself does not enforce this.
module voxel_ray_traversal_3d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  vrt_pkg::ray_t                 in_data,
  output logic                          out_valid,
  output vrt_pkg::result_t              out_data,
  input  logic                          cfg_we,
  input  logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrt_pkg::CFG_W-1:0]     cfg_data
);
  import vrt_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  vrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  vrt_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== dv/voxel_ray_checker.sv =====
// Checker for voxel_ray_traversal_3d: tracks the map bounds, traces every accepted ray
// and compares each result transaction with the oldest expected voxel or end marker.
// Depends on vrt_pkg.
module voxel_ray_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          busy,
  input  vrt_pkg::ray_t                 in_data,
  input  logic                          out_valid,
  input  vrt_pkg::result_t              out_data,
  input  logic                          cfg_we,
  input  logic [vrt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vrt_pkg::CFG_W-1:0]     cfg_data,
  output int                            errors,
  output int                            pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import vrt_pkg::*;

  localparam int ONE_VOXEL = 1 << FRAC_BITS;

  logic signed [INDEX_BITS-1:0] map_lo [3];
  logic signed [INDEX_BITS-1:0] map_hi [3];
  result_t expected_voxels [$];
  result_t want;

  function automatic bit crosses_first(input longint num_a, span_a, num_b, span_b);
    if (span_a == 0) return 1'b0;
    if (span_b == 0) return 1'b1;
    return num_a * span_b < num_b * span_a;
  endfunction

  function automatic void trace_ray(input ray_t r);
    int org [3];
    int cur [3];
    int fin [3];
    int dir [3];
    longint span [3];
    longint xnum [3];
    longint len_sq, reach, q;
    int emitted, steps, ax;
    bit ovf, done, in_map;
    result_t res;
    org[0] = int'(r.start_x);
    org[1] = int'(r.start_y);
    org[2] = int'(r.start_z);
    fin[0] = int'(r.end_x);
    fin[1] = int'(r.end_y);
    fin[2] = int'(r.end_z);
    len_sq = 0;
    for (int a = 0; a < 3; a++) begin
      q = longint'(fin[a] - org[a]);
      len_sq += q * q;
      cur[a] = org[a] >>> FRAC_BITS;
      fin[a] = fin[a] >>> FRAC_BITS;
      dir[a] = (fin[a] > cur[a]) ? 1 : ((fin[a] < cur[a]) ? -1 : 0);
      span[a] = longint'((fin[a] > cur[a]) ? fin[a] - cur[a] : cur[a] - fin[a]);
      xnum[a] = longint'(ONE_VOXEL - (((dir[a] < 0) ? -org[a] : org[a]) & (ONE_VOXEL - 1)));
    end
    emitted = 0;
    steps = 0;
    ovf = 1'b0;
    done = (span[0] == 0 && span[1] == 0 && span[2] == 0);
    while (!done) begin
      in_map = 1'b1;
      for (int a = 0; a < 3; a++)
        if (cur[a] < map_lo[a] || cur[a] >= map_hi[a]) in_map = 1'b0;
      if (in_map && emitted >= MAX_VOXELS) begin
        ovf = 1'b1;
        done = 1'b1;
      end else begin
        if (in_map) begin
          res.voxel_x = cur[0][INDEX_BITS-1:0];
          res.voxel_y = cur[1][INDEX_BITS-1:0];
          res.voxel_z = cur[2][INDEX_BITS-1:0];
          res.voxel_valid = 1'b1;
          res.last = 1'b0;
          res.overflow = 1'b0;
          expected_voxels = {expected_voxels, res};
          emitted++;
          reach = 0;
          for (int a = 0; a < 3; a++) begin
            q = longint'(cur[a] * ONE_VOXEL - org[a]);
            reach += q * q;
          end
          if (reach > len_sq) done = 1'b1;
        end
        if (!done) begin
          if (cur[0] == fin[0] && cur[1] == fin[1] && cur[2] == fin[2]) begin
            done = 1'b1;
          end else if (steps >= MAX_STEPS) begin
            ovf = 1'b1;
            done = 1'b1;
          end else begin
            if (crosses_first(xnum[0], span[0], xnum[1], span[1]))
              ax = crosses_first(xnum[0], span[0], xnum[2], span[2]) ? 0 : 2;
            else
              ax = crosses_first(xnum[1], span[1], xnum[2], span[2]) ? 1 : 2;
            cur[ax] += dir[ax];
            xnum[ax] += ONE_VOXEL;
            steps++;
          end
        end
      end
    end
    res = '0;
    res.last = 1'b1;
    res.overflow = ovf;
    expected_voxels = {expected_voxels, res};
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] exp_val,
                             input logic signed [31:0] got_val);
    if (exp_val !== got_val) begin
      errors++;
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_val, got_val);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        map_lo[a] = INDEX_BITS'(-(1 << (INDEX_BITS - 1)));
        map_hi[a] = INDEX_BITS'((1 << (INDEX_BITS - 1)) - 1);
      end
      expected_voxels.delete();
      errors = 0;
    end else begin
      if (out_valid) begin
        if (expected_voxels.size() == 0) begin
          errors++;
          $display("%0t: result with no ray pending: x %0d y %0d z %0d valid %b last %b ovf %b",
                   $time, out_data.voxel_x, out_data.voxel_y, out_data.voxel_z,
                   out_data.voxel_valid, out_data.last, out_data.overflow);
        end else begin
          want = expected_voxels.pop_front();
          check_field("voxel_x", 32'(want.voxel_x), 32'(out_data.voxel_x));
          check_field("voxel_y", 32'(want.voxel_y), 32'(out_data.voxel_y));
          check_field("voxel_z", 32'(want.voxel_z), 32'(out_data.voxel_z));
          check_field("voxel_valid", 32'(want.voxel_valid), 32'(out_data.voxel_valid));
          check_field("last", 32'(want.last), 32'(out_data.last));
          check_field("overflow", 32'(want.overflow), 32'(out_data.overflow));
        end
      end
      if (start && !busy) trace_ray(in_data);
      if (cfg_we) begin
        unique case (cfg_index)
          REG_MIN_X: map_lo[0] = cfg_data;
          REG_MIN_Y: map_lo[1] = cfg_data;
          REG_MIN_Z: map_lo[2] = cfg_data;
          REG_MAX_X: map_hi[0] = cfg_data;
          REG_MAX_Y: map_hi[1] = cfg_data;
          REG_MAX_Z: map_hi[2] = cfg_data;
          default: ;
        endcase
      end
    end
    pending = expected_voxels.size();
  end

endmodule

// ===== dv/voxel_ray_traversal_3d_test.sv =====
// Top of the voxel_ray_traversal_3d testbench: clock, reset, map settings and ray stimulus.
// Depends on vrt_pkg, voxel_ray_traversal_3d and voxel_ray_checker.
module voxel_ray_traversal_3d_test;
  timeunit 1ns;
  timeprecision 1ps;

  import vrt_pkg::*;

  localparam int ONE_VOXEL = 1 << FRAC_BITS;
  localparam int COORD_MAX = (1 << (COORD_W - 1)) - 1;
  localparam int COORD_MIN = -(1 << (COORD_W - 1));
  localparam int INDEX_MAX = (1 << (INDEX_BITS - 1)) - 1;
  localparam int INDEX_MIN = -(1 << (INDEX_BITS - 1));
  localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  ray_t                 in_data;
  logic                 out_valid;
  result_t              out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   errors;
  int                   pending;

  voxel_ray_traversal_3d dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  voxel_ray_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic ray_t ray_of(input int sx, sy, sz, ex, ey, ez);
    ray_t r;
    r.start_x = COORD_W'(sx);
    r.start_y = COORD_W'(sy);
    r.start_z = COORD_W'(sz);
    r.end_x = COORD_W'(ex);
    r.end_y = COORD_W'(ey);
    r.end_z = COORD_W'(ez);
    return r;
  endfunction

  function automatic ray_t random_ray();
    int s [3];
    int e [3];
    int d, span, fr, tie_d;
    bit tie, full;
    logic signed [COORD_W-1:0] raw;
    span = ($urandom_range(0, 15) == 0) ? 200 : 40;
    tie = ($urandom_range(0, 7) == 0);
    full = ($urandom_range(0, 2) == 0);
    fr = $urandom_range(0, ONE_VOXEL - 1);
    tie_d = int'($urandom_range(0, 2 * span * ONE_VOXEL)) - span * ONE_VOXEL;
    for (int a = 0; a < 3; a++) begin
      if (full) begin
        raw = COORD_W'($urandom);
        s[a] = int'(raw);
      end else begin
        s[a] = int'($urandom_range(0, 40 * ONE_VOXEL)) - 20 * ONE_VOXEL;
      end
      if (tie) begin
        s[a] = (s[a] & ~(ONE_VOXEL - 1)) | fr;
        d = (a < 2 || $urandom_range(0, 1) == 1) ? tie_d : 0;
      end else if ($urandom_range(0, 3) == 0) begin
        d = int'($urandom_range(0, ONE_VOXEL - 1)) - (s[a] & (ONE_VOXEL - 1));
      end else begin
        d = int'($urandom_range(0, 2 * span * ONE_VOXEL)) - span * ONE_VOXEL;
      end
      e[a] = s[a] + d;
      if (e[a] > COORD_MAX) e[a] = COORD_MAX;
      if (e[a] < COORD_MIN) e[a] = COORD_MIN;
    end
    return ray_of(s[0], s[1], s[2], e[0], e[1], e[2]);
  endfunction

  task automatic send_ray(input ray_t r, input int idle_pct);
    logic [5*32-1:0] noise;
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
      in_data = noise[$bits(ray_t)-1:0];
      @(negedge clk);
    end
    start = 1'b1;
    in_data = r;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    start = 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_W'(value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_map(input int lx, ly, lz, hx, hy, hz);
    wait_idle();
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MIN_Z, lz);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MAX_Y, hy);
    write_reg(REG_MAX_Z, hz);
  endtask

  task automatic run_random(input int count, input int idle_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 19) == 0) wait_idle();
      send_ray(random_ray(), idle_pct);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_ray(ray_of(10, 20, 30, 200, 100, 250), 0);
    send_ray(ray_of(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX), 0);
    send_ray(ray_of(255, 255, 255, 257, 255, 255), 0);
    send_ray(ray_of(0, 0, 0, 5 * ONE_VOXEL, 0, 0), 0);
    send_ray(ray_of(128, 128, 128, -1152, -640, -384), 0);
    send_ray(ray_of(128, 128, 128, 896, 896, 896), 0);
    send_ray(ray_of(64, 64, 300, 832, 832, 300), 0);
    send_ray(ray_of(-300, 700, -50, 900, -800, 1200), 0);
    send_ray(ray_of(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX), 0);
    send_ray(ray_of(0, 0, 0, 62 * ONE_VOXEL, 0, 0), 0);
    send_ray(ray_of(0, 0, 0, 63 * ONE_VOXEL, 0, 0), 0);
    send_ray(ray_of(COORD_MAX - 5 * ONE_VOXEL, 0, 0, COORD_MAX, 0, 0), 0);
    send_ray(ray_of(COORD_MIN, COORD_MIN, COORD_MIN,
                    COORD_MIN + 3 * ONE_VOXEL, COORD_MIN + 300, COORD_MIN), 0);
    run_random(22, 0);

    set_map(-4, -4, -4, 8, 8, 8);
    write_reg(REG_NONE_LO, 2);
    write_reg(REG_NONE_HI, 2);
    send_ray(ray_of(-1000 * ONE_VOXEL, 100 * ONE_VOXEL, 100 * ONE_VOXEL,
                    3096 * ONE_VOXEL, 100 * ONE_VOXEL, 100 * ONE_VOXEL), 88);
    send_ray(ray_of(-1000 * ONE_VOXEL, 100 * ONE_VOXEL, 100 * ONE_VOXEL,
                    3097 * ONE_VOXEL, 100 * ONE_VOXEL, 100 * ONE_VOXEL), 88);
    send_ray(ray_of(-10 * ONE_VOXEL, 2 * ONE_VOXEL + 17, -6 * ONE_VOXEL,
                    12 * ONE_VOXEL, 3 * ONE_VOXEL, 10 * ONE_VOXEL), 88);
    run_random(22, 88);

    set_map(INDEX_MIN, INDEX_MIN, INDEX_MIN, INDEX_MAX, INDEX_MAX, INDEX_MAX);
    run_random(25, 18);

    set_map(int'($urandom_range(0, 12)) - 12, int'($urandom_range(0, 12)) - 12,
            int'($urandom_range(0, 12)) - 12, int'($urandom_range(0, 14)) - 2,
            int'($urandom_range(0, 14)) - 2, int'($urandom_range(0, 14)) - 2);
    run_random(25, 88);

    set_map(INDEX_MAX, 3, 0, INDEX_MIN, 3, 1);
    send_ray(ray_of(0, 0, 0, 5000 * ONE_VOXEL, 0, 0), 18);
    send_ray(ray_of(100, 200, 300, 900, -400, 700), 18);
    run_random(20, 18);

    wait_idle();
    if (errors == 0 && pending == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
